[rtl/bfa_pkg.sv]
// Shared types, constants and helpers for the best-fit arena allocator.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package bfa_pkg;

    // Arena and address geometry
    localparam int ARENA_COUNT = 4;
    localparam int CFG_ARENAS  = 4;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = (ARENA_COUNT > 1) ? $clog2(ARENA_COUNT) : 1;

    // Configuration port: bases at 0..CFG_ARENAS-1, limits above them
    localparam int CFG_SEL_W   = $clog2(CFG_ARENAS);
    localparam int CFG_IDX_W   = CFG_SEL_W + 1;

    // Request and result field widths
    localparam int MODE_W      = 3;
    localparam int NAMED_W     = 2;
    localparam int CHOSEN_W    = 2;
    localparam int IN_FIELDS_W = MODE_W + ADDR_W + NAMED_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ADDR_W + 1 + CHOSEN_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NAMED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 3'd4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef addr_t [ARENA_COUNT-1:0] arena_vec_t;
    typedef addr_t [CFG_ARENAS-1:0] cfg_vec_t;

    // Outcome of the arena ranking
    typedef struct packed {
        logic             fits;      // some arena has room above the size
        logic [IDX_W-1:0] best_idx;  // smallest fitting arena
        logic [IDX_W-1:0] max_idx;   // largest arena
    } sel_t;

    // Round a byte count up to a multiple of 16, wrapping at 2^32
    function automatic addr_t round16(input addr_t n);
        addr_t s;
        s = n + addr_t'(15);
        return {s[ADDR_W-1:4], 4'b0000};
    endfunction

endpackage

`default_nettype wire

[rtl/best_fit_arena_allocator.sv]
// Top level of the best-fit arena allocator: request register, arena
// pointers, result register. Depends on bfa_pkg, bfa_cfg_regs, bfa_select.
//
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata, one per cycle at most.
//   Results leave on m_tvalid/m_tready/m_tdata, exactly one per request,
//   in request order.
//   A request waits in the request register until the output is free, and
//   its result is then written to the result register (visible on m_*).
//   Throughput is one request per cycle while the output is free: the
//   ranking, the pointer update and the result are all formed between the
//   request register and the result register, and the arena pointers are
//   written at the same edge, so the next request already sees them.
//   When the receiver stalls, the result register holds; one more request
//   waits in the request register, after which s_tready drops.
//   Reset (aresetn low, synchronous) empties both registers and clears the
//   configuration registers and all arena pointers to zero.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at the
//   edge and are meant for idle periods; a reload request copies them
//   into the arena pointers.
`default_nettype none

module best_fit_arena_allocator import bfa_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Request: [2:0] mode, [34:3] request_size, [36:35] arena_index
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result: [31:0] address, [32] failed, [34:33] chosen_arena
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // Configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ADDR_W-1:0]      cfg_wdata
);

    // Request register
    logic                in_valid_reg;
    logic [MODE_W-1:0]   in_mode_reg;
    addr_t               in_size_reg;
    logic [NAMED_W-1:0]  in_named_reg;

    // Arena pointers
    arena_vec_t start_reg, start_next;
    arena_vec_t end_reg, end_next;

    // Result register
    logic                out_valid_reg;
    addr_t               out_addr_reg, out_addr_next;
    logic                out_failed_reg, out_failed_next;
    logic [CHOSEN_W-1:0] out_chosen_reg, out_chosen_next;

    cfg_vec_t            cfg_base;
    cfg_vec_t            cfg_limit;
    sel_t                sel;
    logic [IDX_W-1:0]    sel_idx;
    logic [IDX_W-1:0]    named_idx;
    logic                named_ok;
    addr_t               size_r16;
    addr_t               sel_room;
    logic                advance;

    bfa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .base_o    (cfg_base),
        .limit_o   (cfg_limit)
    );

    bfa_select u_sel (
        .start_i (start_reg),
        .end_i   (end_reg),
        .size_i  (in_size_reg),
        .sel_o   (sel)
    );

    // Handshake: the request moves on when the result slot is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tdata[MODE_W-1:0];
            in_size_reg  <= s_tdata[MODE_W +: ADDR_W];
            in_named_reg <= s_tdata[MODE_W+ADDR_W +: NAMED_W];
        end
    end

    // Request decode
    assign sel_idx   = sel.fits ? sel.best_idx : sel.max_idx;
    assign sel_room  = end_reg[sel_idx] - start_reg[sel_idx];
    assign size_r16  = round16(in_size_reg);
    assign named_ok  = 32'(in_named_reg) < 32'(ARENA_COUNT);
    assign named_idx = IDX_W'(in_named_reg);

    always_comb begin
        start_next      = start_reg;
        end_next        = end_reg;
        out_addr_next   = '0;
        out_failed_next = 1'b0;
        out_chosen_next = '0;
        unique case (in_mode_reg)
            MODE_FRONT: begin
                out_chosen_next     = CHOSEN_W'(sel_idx);
                out_addr_next       = start_reg[sel_idx];
                start_next[sel_idx] = start_reg[sel_idx] + size_r16;
            end
            MODE_PEEK: begin
                out_chosen_next = CHOSEN_W'(sel_idx);
                out_addr_next   = start_reg[sel_idx];
            end
            MODE_BACK: begin
                out_chosen_next = CHOSEN_W'(sel_idx);
                if (sel.fits) begin
                    end_next[sel_idx] = end_reg[sel_idx] - size_r16;
                    out_addr_next     = end_reg[sel_idx] - size_r16;
                end else begin
                    out_failed_next = 1'b1;
                end
            end
            MODE_NAMED: begin
                out_chosen_next = CHOSEN_W'(in_named_reg);
                if (named_ok) begin
                    out_addr_next         = start_reg[named_idx];
                    start_next[named_idx] = start_reg[named_idx] + size_r16;
                end
            end
            MODE_RELOAD: begin
                for (int k = 0; k < ARENA_COUNT; k++) begin
                    if (k < CFG_ARENAS) begin
                        start_next[k] = cfg_base[k % CFG_ARENAS];
                        end_next[k]   = cfg_limit[k % CFG_ARENAS];
                    end else begin
                        start_next[k] = '0;
                        end_next[k]   = '0;
                    end
                end
            end
            default: begin
                // unused modes leave everything alone
            end
        endcase
    end

    // Arena pointers follow each processed request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '0;
        end else if (advance) begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_addr_reg   <= out_addr_next;
            out_failed_reg <= out_failed_next;
            out_chosen_reg <= out_chosen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                       out_chosen_reg, out_failed_reg, out_addr_reg};

    // Only a back allocation can fail
    a_fail_only_back: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_failed_next |-> in_mode_reg == MODE_BACK)
        else $error("failure flagged outside back allocation");

    // A fitting choice really has more room than the request
    a_fit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && sel.fits |-> in_size_reg < sel_room)
        else $error("best-fit arena lacks room");

    // Without a fit, the largest arena cannot hold the request either
    a_nofit_no_room: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !sel.fits |-> sel_room <= in_size_reg)
        else $error("no-fit declared while an arena has room");

    // A held request blocks new ones
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> !s_tready)
        else $error("request register overwritten while held");

    // Pointers change only when a request is processed
    a_ptr_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(start_reg) && $stable(end_reg))
        else $error("arena pointers moved without a request");

endmodule

`default_nettype wire

[rtl/bfa_cfg_regs.sv]
// Configuration register file: reload bases and limits for each arena.
// Depends on bfa_pkg.
`default_nettype none

module bfa_cfg_regs import bfa_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_wdata,
    output cfg_vec_t                  base_o,
    output cfg_vec_t                  limit_o
);

    cfg_vec_t base_reg;
    cfg_vec_t limit_reg;

    // Top index bit picks the limit bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            limit_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index[CFG_IDX_W-1]) begin
                limit_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_wdata;
            end else begin
                base_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_wdata;
            end
        end
    end

    assign base_o  = base_reg;
    assign limit_o = limit_reg;

endmodule

`default_nettype wire

[rtl/bfa_select.sv]
// Arena ranking: free space per arena, smallest fitting and largest arena.
// Depends on bfa_pkg. Pure combinational logic: parallel compares feeding a
// bubble network that only moves arena indices.
`default_nettype none

module bfa_select import bfa_pkg::*; (
    input  wire arena_vec_t        start_i,
    input  wire arena_vec_t        end_i,
    input  wire logic [ADDR_W-1:0] size_i,
    output sel_t                   sel_o
);

    addr_t                  room  [ARENA_COUNT];
    logic [ARENA_COUNT-1:0] fit;
    logic [ARENA_COUNT-1:0] ge    [ARENA_COUNT];
    logic [IDX_W-1:0]       order [ARENA_COUNT];

    // Free space, fit flag and every pairwise greater-or-equal, side by side
    always_comb begin
        for (int k = 0; k < ARENA_COUNT; k++) begin
            room[k] = end_i[k] - start_i[k];
            fit[k]  = size_i < room[k];
        end
        for (int a = 0; a < ARENA_COUNT; a++) begin
            for (int b = 0; b < ARENA_COUNT; b++) begin
                ge[a][b] = room[a] >= room[b];
            end
        end
    end

    // Bubble network on indices: neighbors swap when the left room is
    // greater or equal, which fixes where equal rooms land
    always_comb begin
        logic [IDX_W-1:0] t;
        t = '0;
        for (int k = 0; k < ARENA_COUNT; k++) begin
            order[k] = IDX_W'(k);
        end
        for (int i = ARENA_COUNT - 1; i > 0; i--) begin
            for (int j = 0; j < i; j++) begin
                if (ge[order[j]][order[j+1]]) begin
                    t          = order[j];
                    order[j]   = order[j+1];
                    order[j+1] = t;
                end
            end
        end
    end

    // First fitting arena in rank order; the last ranked one is the largest
    always_comb begin
        sel_o.fits     = |fit;
        sel_o.max_idx  = order[ARENA_COUNT-1];
        sel_o.best_idx = order[ARENA_COUNT-1];
        for (int i = ARENA_COUNT - 1; i >= 0; i--) begin
            if (fit[order[i]]) begin
                sel_o.best_idx = order[i];
            end
        end
    end

endmodule

`default_nettype wire
